@@ src/assert_macros.svh @@
// Assertion helpers, checked in simulation only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rstn, expr)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ src/kpls_pkg.sv @@
package kpls_pkg;

    localparam int KEY_BITS = 24;
    localparam int IDX_W    = 5;
    localparam int TIME_W   = 32;
    localparam int DELAY_W  = 16;

    localparam int DEF_ROWS = 3;
    localparam int DEF_COLS = 8;

    localparam logic [IDX_W-1:0]   NO_KEY      = 5'd31;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd1000;

    typedef logic [IDX_W-1:0]    key_idx_t;
    typedef logic [TIME_W-1:0]   time_ms_t;
    typedef logic [DELAY_W-1:0]  delay_ms_t;
    typedef logic [KEY_BITS-1:0] matrix_t;

    typedef struct packed {
        logic     valid;
        key_idx_t key_index;
        logic     shifted;
    } report_t;

endpackage

@@ src/keypad_scan_long_press_shift.sv @@
// An accepted word waits in the input register; its result, if it has one,
// moves to the output register once that one is empty or m_ready is high.
// Throughput: one word per cycle while that holds; key pick, deadline add
// and wrap compare all sit between the input and the result register.
// Reset (aresetn, synchronous, active low): no key held, deadline and shift
// mark cleared, hold_delay_ms back to 1000, both word registers empty.
module keypad_scan_long_press_shift #(
    parameter int ROWS = kpls_pkg::DEF_ROWS,
    parameter int COLS = kpls_pkg::DEF_COLS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  kpls_pkg::delay_ms_t cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  kpls_pkg::matrix_t   s_key_matrix,
    input  kpls_pkg::time_ms_t  s_now_ms,
    output logic                m_valid,
    input  logic                m_ready,
    output kpls_pkg::key_idx_t  m_key_index,
    output logic                m_shifted
);
    import kpls_pkg::*;

    delay_ms_t hold_delay_reg;

    logic      in_valid_reg, in_valid_next;
    matrix_t   in_matrix_reg;
    time_ms_t  in_now_reg;

    logic      out_valid_reg, out_valid_next;
    key_idx_t  out_index_reg;
    logic      out_shifted_reg;

    logic      out_free;
    logic      step;
    key_idx_t  key;
    report_t   rpt;

    assign cfg_ready = 1'b1;

    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (step && rpt.valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_delay_reg <= DELAY_RESET;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                hold_delay_reg <= cfg_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_matrix_reg <= s_key_matrix;
            in_now_reg    <= s_now_ms;
        end
        if (step && rpt.valid) begin
            out_index_reg   <= rpt.key_index;
            out_shifted_reg <= rpt.shifted;
        end
    end

    kpls_pick #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_pick (
        .key_matrix (in_matrix_reg),
        .key        (key)
    );

    kpls_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .key           (key),
        .now_ms        (in_now_reg),
        .hold_delay_ms (hold_delay_reg),
        .rpt           (rpt)
    );

    assign m_valid     = out_valid_reg;
    assign m_key_index = out_index_reg;
    assign m_shifted   = out_shifted_reg;

endmodule

@@ src/kpls_pick.sv @@
module kpls_pick #(
    parameter int ROWS = kpls_pkg::DEF_ROWS,
    parameter int COLS = kpls_pkg::DEF_COLS
) (
    input  kpls_pkg::matrix_t  key_matrix,
    output kpls_pkg::key_idx_t key
);
    import kpls_pkg::*;

    logic [ROWS-1:0][COLS-1:0] hit;

    // cells whose index falls past the matrix word are never pressed
    for (genvar gr = 0; gr < ROWS; gr++) begin : g_row
        for (genvar gc = 0; gc < COLS; gc++) begin : g_col
            localparam int CELL = gr + gc * ROWS;
            if (CELL < KEY_BITS) begin : g_on
                assign hit[gr][gc] = key_matrix[CELL];
            end else begin : g_off
                assign hit[gr][gc] = 1'b0;
            end
        end
    end

    // highest row wins, then highest column within it
    always_comb begin
        key = NO_KEY;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                if (hit[r][c]) begin
                    key = IDX_W'(r + c * ROWS);
                end
            end
        end
    end

endmodule

@@ src/kpls_ctrl.sv @@
`include "assert_macros.svh"

module kpls_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  kpls_pkg::key_idx_t  key,
    input  kpls_pkg::time_ms_t  now_ms,
    input  kpls_pkg::delay_ms_t hold_delay_ms,
    output kpls_pkg::report_t   rpt
);
    import kpls_pkg::*;

    key_idx_t prev_key_reg, prev_key_next;
    time_ms_t deadline_reg, deadline_next;
    logic     shift_taken_reg, shift_taken_next;

    time_ms_t deadline_sum;
    time_ms_t diff;
    logic     time_after;

    assign deadline_sum = now_ms + TIME_W'(hold_delay_ms);
    assign diff         = now_ms - deadline_reg;
    // wrap-safe: strictly later and less than half the clock range ahead
    assign time_after   = (diff != '0) && !diff[TIME_W-1];

    always_comb begin
        prev_key_next    = prev_key_reg;
        deadline_next    = deadline_reg;
        shift_taken_next = shift_taken_reg;
        rpt.valid        = 1'b0;
        rpt.key_index    = prev_key_reg;
        rpt.shifted      = 1'b0;
        if (step) begin
            prev_key_next = key;
            if (key != prev_key_reg) begin
                shift_taken_next = 1'b0;
                if (key != NO_KEY) begin
                    deadline_next = deadline_sum;
                end else if (!shift_taken_reg) begin
                    rpt.valid = 1'b1;   // release before long press
                end
            end else if (key != NO_KEY && !shift_taken_reg && time_after) begin
                shift_taken_next = 1'b1;
                rpt.valid        = 1'b1;
                rpt.shifted      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_key_reg    <= NO_KEY;
            deadline_reg    <= '0;
            shift_taken_reg <= 1'b0;
        end else begin
            prev_key_reg    <= prev_key_next;
            deadline_reg    <= deadline_next;
            shift_taken_reg <= shift_taken_next;
        end
    end

    `ASSERT_IMPLIES(a_no_null_report, aclk, aresetn, rpt.valid, rpt.key_index != NO_KEY)
    `ASSERT_ALWAYS(a_shift_needs_key, aclk, aresetn, !shift_taken_reg || prev_key_reg != NO_KEY)
    `ASSERT_NEXT(a_shift_marks, aclk, aresetn, rpt.valid && rpt.shifted, shift_taken_reg)

endmodule
